@@ rtl/profile_column_score_engine_defines.svh @@
// ---------------------------------------------------------------------------
// profile column score engine assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef PROFILE_COLUMN_SCORE_ENGINE_DEFINES_SVH
`define PROFILE_COLUMN_SCORE_ENGINE_DEFINES_SVH

// same-cycle implication
`define PCSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// plain invariant
`define PCSE_ASSERT_ALW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

@@ rtl/pcse_pkg.sv @@
// ---------------------------------------------------------------------------
// pcse_pkg
// types, sizes, codes and address helper of the profile column score engine
// ---------------------------------------------------------------------------
package pcse_pkg;

    localparam int COLS     = 1024;
    localparam int FEATURES = 4;
    localparam int ALPHA    = 32;

    localparam int LANE_DEPTH = COLS * ALPHA;
    localparam int ADDR_W     = $clog2(LANE_DEPTH);

    localparam int SCORE_W = 16;
    localparam int SUM_W   = 18;
    localparam int CFG_W   = 3;

    localparam logic [7:0] GAP_LETTER  = 8'd255;
    localparam logic [7:0] AMINO_LIMIT = 8'd20;

    // request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_PROFILE = 2'd1;
    localparam logic [1:0] REQ_SEQ     = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    // register indexes
    localparam logic REG_FEATURE_COUNT = 1'b0;
    localparam logic REG_AMINO_FEATURE = 1'b1;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [ADDR_W-1:0]         t_addr;

    // per-transaction control carried alongside the ram read
    typedef struct packed {
        logic                query;
        logic [FEATURES-1:0] use_lane;
        logic                letter_error;
    } t_lane_ctrl;

    // status back from the summing stage
    typedef struct packed {
        logic s1_valid;
        logic take;
    } t_acc_stat;

    // lane address: column row of ALPHA letters
    function automatic t_addr pcse_addr(input logic [9:0] col, input logic [7:0] letter);
        pcse_addr = ADDR_W'(int'(col) * ALPHA + int'(letter));
    endfunction

endpackage

@@ rtl/pcse_req_if.sv @@
// ---------------------------------------------------------------------------
// pcse_req_if
// request channel: table loads and score queries
// ---------------------------------------------------------------------------
interface pcse_req_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [9:0]  col_index;
    logic [1:0]  feature_index;
    logic [4:0]  letter_index;
    logic signed [15:0] score_value;
    logic [7:0]  feat_letter_0;
    logic [7:0]  feat_letter_1;
    logic [7:0]  feat_letter_2;
    logic [7:0]  feat_letter_3;
    logic [7:0]  amino_letter;

    modport source (
        output valid, req_type, col_index, feature_index, letter_index, score_value,
               feat_letter_0, feat_letter_1, feat_letter_2, feat_letter_3, amino_letter,
        input  ready
    );
    modport sink (
        input  valid, req_type, col_index, feature_index, letter_index, score_value,
               feat_letter_0, feat_letter_1, feat_letter_2, feat_letter_3, amino_letter,
        output ready
    );
endinterface

@@ rtl/pcse_rsp_if.sv @@
// ---------------------------------------------------------------------------
// pcse_rsp_if
// result channel: summed score and letter flag
// ---------------------------------------------------------------------------
interface pcse_rsp_if ();
    logic               valid;
    logic               ready;
    logic signed [17:0] pair_score;
    logic               letter_error;

    modport source (output valid, pair_score, letter_error, input ready);
    modport sink   (input valid, pair_score, letter_error, output ready);
endinterface

@@ rtl/pcse_cfg_if.sv @@
// ---------------------------------------------------------------------------
// pcse_cfg_if
// configuration write channel
// ---------------------------------------------------------------------------
interface pcse_cfg_if ();
    logic       valid;
    logic       ready;
    logic       index;
    logic [2:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/pcse_feat_ram.sv @@
// ---------------------------------------------------------------------------
// pcse_feat_ram
// single-port synchronous ram, registered read, one access per cycle
// ---------------------------------------------------------------------------
module pcse_feat_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/pcse_accum.sv @@
// ---------------------------------------------------------------------------
// pcse_accum
// lane control stage, lane sum and output register with backpressure
// ---------------------------------------------------------------------------
module pcse_accum
    import pcse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_lane_ctrl i_ctrl,
    input  t_score     i_lane_data [FEATURES],
    pcse_rsp_if.source o_rsp,
    output t_acc_stat  o_stat
);
    logic       r_s1_valid;
    t_lane_ctrl r_s1_ctrl;
    logic       r_out_valid;
    t_sum       r_pair_score;
    logic       r_letter_error;
    logic       adv;
    t_sum       n_pair_score;

    // stage 1 moves on when the output register is free or being emptied
    assign adv = r_s1_valid && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_pair_score = '0;
        for (int f = 0; f < FEATURES; f++) begin
            if (r_s1_ctrl.use_lane[f]) begin
                n_pair_score = n_pair_score + SUM_W'(i_lane_data[f]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= i_ctrl.query;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctrl <= i_ctrl;
        end
        if (adv) begin
            r_pair_score   <= n_pair_score;
            r_letter_error <= r_s1_ctrl.letter_error;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.pair_score   = r_pair_score;
    assign o_rsp.letter_error = r_letter_error;

    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.take     = !r_s1_valid || adv;
endmodule

@@ rtl/profile_column_score_engine.sv @@
// ---------------------------------------------------------------------------
// profile_column_score_engine
// per-column, per-feature letter score tables with summed profile queries
// ---------------------------------------------------------------------------
// usage
// - i_req carries one transaction per accepted cycle: a table load (no result),
//   a profile column query or a sequence letter query (one result each);
//   the unused request code is taken and dropped
// - o_rsp returns pair_score and letter_error in request order
// - i_cfg writes feature_count (index 0) and amino_feature (index 1); it is
//   always ready and is meant to be written while no query is in flight
// - one feature table per ram, so all lanes of a query read in the same cycle;
//   a load writes its single ram at the accept edge, so a following query
//   already sees the new entry
// - the ram read is registered at the accepting edge; the lane sum then goes
//   into the output register once that register is free or being emptied, and
//   o_rsp.valid rises with it
// - throughput: one transaction per cycle while o_rsp keeps up, set by the
//   single ram port of each feature lane
// - reset clears the pipeline valids and the registers (feature_count 4,
//   amino_feature 0); the tables are not cleared and read as garbage until
//   loaded
// - a stalled receiver holds the output register; one more query can sit in
//   the read stage, after that i_req.ready drops until o_rsp moves
// ---------------------------------------------------------------------------
`include "profile_column_score_engine_defines.svh"

module profile_column_score_engine
    import pcse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    pcse_req_if.sink i_req,
    pcse_cfg_if.sink i_cfg,
    pcse_rsp_if.source o_rsp
);
    logic [2:0] r_feature_count;
    logic [1:0] r_amino_feature;

    logic                accept;
    logic                col_ok;
    logic                load_ok;
    logic [7:0]          letters  [4];
    logic [FEATURES-1:0] ram_en;
    logic [FEATURES-1:0] ram_we;
    t_addr               ram_addr [FEATURES];
    t_score              lane_data[FEATURES];
    t_lane_ctrl          ctrl;
    t_acc_stat           stat;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= 3'd4;
            r_amino_feature <= 2'd0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FEATURE_COUNT: r_feature_count <= i_cfg.data;
                REG_AMINO_FEATURE: r_amino_feature <= i_cfg.data[1:0];
            endcase
        end
    end

    // request decode
    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = stat.take;

    assign col_ok  = 32'(i_req.col_index) < COLS;
    assign load_ok = col_ok && (32'(i_req.feature_index) < FEATURES)
                   && (32'(i_req.letter_index) < ALPHA);

    assign letters[0] = i_req.feat_letter_0;
    assign letters[1] = i_req.feat_letter_1;
    assign letters[2] = i_req.feat_letter_2;
    assign letters[3] = i_req.feat_letter_3;

    always_comb begin
        logic [7:0] rd_letter;
        logic       live;
        logic       gap;
        logic       in_alpha;
        ctrl.query        = (i_req.req_type == REQ_PROFILE) || (i_req.req_type == REQ_SEQ);
        ctrl.letter_error = 1'b0;
        ctrl.use_lane     = '0;
        for (int f = 0; f < FEATURES; f++) begin
            rd_letter = (i_req.req_type == REQ_SEQ) ? i_req.amino_letter : letters[f];
            // lanes past feature_count drop out of a profile query
            live      = 3'(f) < r_feature_count;
            gap       = rd_letter == GAP_LETTER;
            in_alpha  = 32'(rd_letter) < ALPHA;
            unique case (i_req.req_type)
                REQ_PROFILE: begin
                    ctrl.use_lane[f] = col_ok && live && !gap && in_alpha;
                    if (col_ok && live && !gap && !in_alpha) begin
                        ctrl.letter_error = 1'b1;
                    end
                end
                REQ_SEQ: begin
                    ctrl.use_lane[f] = col_ok && (2'(f) == r_amino_feature)
                                     && (rd_letter < AMINO_LIMIT) && in_alpha;
                end
                REQ_LOAD, REQ_NONE: begin
                    ctrl.use_lane[f] = 1'b0;
                end
            endcase
            ram_we[f]   = accept && (i_req.req_type == REQ_LOAD) && load_ok
                        && (i_req.feature_index == 2'(f));
            ram_en[f]   = ram_we[f] || (accept && ctrl.use_lane[f]);
            ram_addr[f] = ram_we[f] ? pcse_addr(i_req.col_index, 8'(i_req.letter_index))
                                    : pcse_addr(i_req.col_index, rd_letter);
        end
    end

    // one table ram per feature lane
    for (genvar g = 0; g < FEATURES; g++) begin : g_lane
        pcse_feat_ram #(
            .DEPTH (LANE_DEPTH),
            .WIDTH (SCORE_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (ram_en[g]),
            .i_we    (ram_we[g]),
            .i_addr  (ram_addr[g]),
            .i_wdata (i_req.score_value),
            .o_rdata (lane_data[g])
        );
    end

    // lane sum and output register
    pcse_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ctrl      (ctrl),
        .i_lane_data (lane_data),
        .o_rsp       (o_rsp),
        .o_stat      (stat)
    );

    // checks
    `PCSE_ASSERT_ALW(a_one_write, $onehot0(ram_we), "more than one lane ram written")
    `PCSE_ASSERT_NXT(a_query_staged, accept && ctrl.query, stat.s1_valid,
        "accepted query not staged")
    `PCSE_ASSERT_NXT(a_load_silent, accept && !ctrl.query, !stat.s1_valid,
        "load or unknown request staged a result")
    `PCSE_ASSERT_IMP(a_full_stall, stat.s1_valid && o_rsp.valid && !o_rsp.ready,
        !i_req.ready, "request taken while both stages are blocked")
    `PCSE_ASSERT_IMP(a_write_no_read, (ram_we != '0), !ctrl.query,
        "table write during a query")
endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the profile column score engine: table loads,
// profile column and sequence letter queries go in through the request
// channel, a local copy of the score tables predicts each result, and every
// result transaction is compared field by field in arrival order
// ---------------------------------------------------------------------------
module tb_top;
    import pcse_pkg::*;

    localparam int TABLE_DEPTH  = COLS * FEATURES * ALPHA;
    localparam int IDLE_LIMIT   = 2000;  // longest receiver hold is HOLD_CYCLES
    localparam int DRAIN_CYCLES = 4;     // two-stage pipeline plus margin
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 80;

    // one request transaction as the bench sees it
    typedef struct packed {
        logic [1:0]       req_type;
        logic [9:0]       col_index;
        logic [1:0]       feature_index;
        logic [4:0]       letter_index;
        logic signed [15:0] score_value;
        logic [3:0][7:0]  feat_letters;
        logic [7:0]       amino_letter;
    } t_score_req;

    // one predicted result transaction
    typedef struct packed {
        t_sum pair_score;
        logic letter_error;
    } t_score_result;

    logic i_clk;
    logic i_rst_n;

    pcse_req_if req_bus ();
    pcse_cfg_if cfg_bus ();
    pcse_rsp_if rsp_bus ();

    profile_column_score_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    // local copy of the score tables and the two registers
    logic signed [15:0] column_scores [0:TABLE_DEPTH-1];
    bit                 entry_loaded  [0:TABLE_DEPTH-1];
    bit                 column_seen   [0:COLS-1];
    int                 loaded_cols[$];
    int                 hot_cols[8];
    logic [2:0]         cur_feature_count = 3'd4;
    logic [1:0]         cur_amino_feature = 2'd0;

    // results still owed by the block, oldest first
    t_score_result pending_scores[$];

    int fail_count = 0;
    bit no_idle    = 1'b0;   // both sides run without gaps while set
    int rsp_hold   = 0;      // one-shot long hold-off for the receiver
    int idle_cycles = 0;

    // clock, period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // table address: column row of FEATURES tables of ALPHA letters
    function automatic int table_addr(input int col, input int feat, input int letter);
        return (col * FEATURES + feat) * ALPHA + letter;
    endfunction

    // a load updates the table copy, a query queues its result
    function automatic void predict_column_score(input t_score_req it);
        int            addr;
        int            sum;
        int            enabled;
        logic          flag;
        logic [7:0]    letter;
        t_score_result res;
        sum  = 0;
        flag = 1'b0;
        unique case (it.req_type)
            REQ_LOAD: begin
                addr = table_addr(int'(it.col_index), int'(it.feature_index),
                                  int'(it.letter_index));
                column_scores[addr] = it.score_value;
                entry_loaded[addr]  = 1'b1;
                if (!column_seen[it.col_index]) begin
                    column_seen[it.col_index] = 1'b1;
                    loaded_cols = {loaded_cols, int'(it.col_index)};
                end
            end
            REQ_PROFILE: begin
                // feature count clamps at the number of tables
                enabled = (int'(cur_feature_count) > FEATURES) ? FEATURES
                                                               : int'(cur_feature_count);
                for (int f = 0; f < enabled; f++) begin
                    letter = it.feat_letters[f];
                    if (letter == GAP_LETTER) begin
                        // gap adds nothing
                    end else if (int'(letter) >= ALPHA) begin
                        flag = 1'b1;
                    end else begin
                        sum += column_scores[table_addr(int'(it.col_index), f,
                                                        int'(letter))];
                    end
                end
                res.pair_score   = t_sum'(sum);
                res.letter_error = flag;
                pending_scores = {pending_scores, res};
            end
            REQ_SEQ: begin
                if (it.amino_letter < AMINO_LIMIT && int'(it.amino_letter) < ALPHA &&
                    int'(cur_amino_feature) < FEATURES) begin
                    sum = column_scores[table_addr(int'(it.col_index),
                                                   int'(cur_amino_feature),
                                                   int'(it.amino_letter))];
                end
                res.pair_score   = t_sum'(sum);
                res.letter_error = 1'b0;
                pending_scores = {pending_scores, res};
            end
            REQ_NONE: begin
                // unused code is dropped
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------

    function automatic t_score_req random_fields();
        t_score_req it;
        it.req_type      = 2'($urandom);
        it.col_index     = 10'($urandom);
        it.feature_index = 2'($urandom);
        it.letter_index  = 5'($urandom);
        it.score_value   = 16'($urandom);
        it.feat_letters  = 32'($urandom);
        it.amino_letter  = 8'($urandom);
        return it;
    endfunction

    function automatic t_score_req make_load(input int col, input int feat, input int letter,
                                             input logic signed [15:0] value);
        t_score_req it;
        it               = random_fields();
        it.req_type      = REQ_LOAD;
        it.col_index     = 10'(col);
        it.feature_index = 2'(feat);
        it.letter_index  = 5'(letter);
        it.score_value   = value;
        return it;
    endfunction

    function automatic t_score_req make_profile(input int col, input int l0, input int l1,
                                                input int l2, input int l3);
        t_score_req it;
        it                 = random_fields();
        it.req_type        = REQ_PROFILE;
        it.col_index       = 10'(col);
        it.feat_letters[0] = 8'(l0);
        it.feat_letters[1] = 8'(l1);
        it.feat_letters[2] = 8'(l2);
        it.feat_letters[3] = 8'(l3);
        return it;
    endfunction

    function automatic t_score_req make_seq(input int col, input int amino);
        t_score_req it;
        it              = random_fields();
        it.req_type     = REQ_SEQ;
        it.col_index    = 10'(col);
        it.amino_letter = 8'(amino);
        return it;
    endfunction

    // a loaded letter below limit for this column and feature, or -1
    function automatic int pick_loaded_letter(input int col, input int feat, input int limit);
        int cand[ALPHA];
        int cnt;
        cnt = 0;
        for (int l = 0; l < limit; l++) begin
            if (entry_loaded[table_addr(col, feat, l)]) begin
                cand[cnt] = l;
                cnt++;
            end
        end
        if (cnt == 0) return -1;
        return cand[$urandom_range(0, cnt - 1)];
    endfunction

    function automatic int pick_column();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // offer one transaction, predict it at the accepting edge
    task automatic issue_request(input t_score_req it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= it.req_type;
        req_bus.col_index     <= it.col_index;
        req_bus.feature_index <= it.feature_index;
        req_bus.letter_index  <= it.letter_index;
        req_bus.score_value   <= it.score_value;
        req_bus.feat_letter_0 <= it.feat_letters[0];
        req_bus.feat_letter_1 <= it.feat_letters[1];
        req_bus.feat_letter_2 <= it.feat_letters[2];
        req_bus.feat_letter_3 <= it.feat_letters[3];
        req_bus.amino_letter  <= it.amino_letter;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
        predict_column_score(it);
    endtask

    // stop offering, let every owed result and any load in flight settle
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [2:0] value);
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        if (idx == REG_FEATURE_COUNT) cur_feature_count = value;
        else cur_amino_feature = value[1:0];
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed traffic: queries only read entries already loaded
    task automatic send_random_items(input int count, input int load_pct);
        t_score_req it;
        int         r;
        int         l;
        int         enabled;
        int         col;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < load_pct) begin
                col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COLS - 1)
                                                  : hot_cols[$urandom_range(0, 7)];
                it = make_load(col, $urandom_range(0, 3), $urandom_range(0, ALPHA - 1),
                               16'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    col = pick_column();
                    it  = make_profile(col, $urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255));
                    enabled = (int'(cur_feature_count) > FEATURES) ? FEATURES
                                                                   : int'(cur_feature_count);
                    // features past the count keep their random letters
                    for (int f = 0; f < enabled; f++) begin
                        r = $urandom_range(0, 99);
                        l = pick_loaded_letter(col, f, ALPHA);
                        if (r < 65 && l >= 0) it.feat_letters[f] = 8'(l);
                        else if (r < 82) it.feat_letters[f] = GAP_LETTER;
                        else it.feat_letters[f] = 8'($urandom_range(ALPHA, 254));
                    end
                end else if (r < 92) begin
                    col = pick_column();
                    l   = pick_loaded_letter(col, int'(cur_amino_feature), int'(AMINO_LIMIT));
                    if ($urandom_range(0, 99) < 70 && l >= 0) it = make_seq(col, l);
                    else it = make_seq(col, $urandom_range(int'(AMINO_LIMIT), 255));
                end else begin
                    it          = random_fields();
                    it.req_type = REQ_NONE;
                end
            end
            issue_request(it);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker, with random stalls and a one-shot long hold
    // ------------------------------------------------------------------
    initial begin
        int            stall;
        bit            taken;
        t_score_result want;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rsp_hold > 0) begin
                stall    = rsp_hold;
                rsp_hold = 0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 4);
            end
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            taken = 1'b0;
            while (!taken) begin
                @(posedge i_clk);
                if (rsp_bus.valid && rsp_bus.ready) begin
                    taken = 1'b1;
                    if (pending_scores.size() == 0) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("unexpected result: score %0d flag %0b",
                                     rsp_bus.pair_score, rsp_bus.letter_error);
                    end else begin
                        want = pending_scores.pop_front();
                        if (rsp_bus.pair_score !== want.pair_score ||
                            rsp_bus.letter_error !== want.letter_error) begin
                            fail_count++;
                            if (fail_count <= REPORT_LIMIT)
                                $display("mismatch: score exp %0d got %0d, flag exp %0b got %0b",
                                         want.pair_score, rsp_bus.pair_score,
                                         want.letter_error, rsp_bus.letter_error);
                        end
                    end
                end else if (rsp_hold > 0) begin
                    // hold request arrived while waiting, go lower ready
                    taken = 1'b1;
                end
            end
        end
    end

    // watchdog: any accepted transaction on any channel resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) ||
            (rsp_bus.valid && rsp_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extreme scores, gaps, bad letters, amino limit, unused code
    task automatic test_directed_extremes();
        t_score_req it;
        for (int f = 0; f < FEATURES; f++) begin
            issue_request(make_load(0, f, ALPHA - 1, 16'sh8000));
            issue_request(make_load(COLS - 1, f, ALPHA - 1, 16'sh7fff));
        end
        issue_request(make_load(0, 0, 0, 16'sh0100));
        issue_request(make_load(0, 0, int'(AMINO_LIMIT) - 1, 16'sh7f00));
        // full positive and full negative sums
        issue_request(make_profile(COLS - 1, 31, 31, 31, 31));
        issue_request(make_profile(0, 31, 31, 31, 31));
        // all gaps
        issue_request(make_profile(0, 255, 255, 255, 255));
        // bad letters flag the result, gap does not
        issue_request(make_profile(0, 31, ALPHA, 255, 254));
        issue_request(make_profile(0, 0, 255, 255, 255));
        // sequence queries around the amino limit
        issue_request(make_seq(0, 0));
        issue_request(make_seq(0, int'(AMINO_LIMIT) - 1));
        issue_request(make_seq(0, int'(AMINO_LIMIT)));
        issue_request(make_seq(COLS - 1, 255));
        // unused request code gives nothing
        it          = random_fields();
        it.req_type = REQ_NONE;
        issue_request(it);
        issue_request(make_profile(COLS - 1, 31, 31, 31, 31));
    endtask

    // feature count 0, 1 and 7, amino table 3, and the upper amino data bit
    task automatic test_register_extremes();
        issue_request(make_load(COLS - 1, 3, 5, 16'sh1234));
        write_register(REG_FEATURE_COUNT, 3'd0);
        issue_request(make_profile(COLS - 1, 31, 31, 31, 31));
        issue_request(make_profile(0, 200, 100, 40, 33));
        write_register(REG_FEATURE_COUNT, 3'd7);
        issue_request(make_profile(COLS - 1, 31, 31, 31, 31));
        write_register(REG_FEATURE_COUNT, 3'd1);
        issue_request(make_profile(0, 31, 40, 40, 40));
        write_register(REG_AMINO_FEATURE, 3'd3);
        issue_request(make_seq(COLS - 1, 5));
        // upper data bit is outside the amino register
        write_register(REG_AMINO_FEATURE, 3'b110);
        issue_request(make_seq(COLS - 1, 200));
    endtask

    // random traffic under a range of register settings
    task automatic test_random_phases();
        int phase_fc[PHASES] = '{4, 1, 0, 7, 2, 3, 5, 6};
        int phase_af[PHASES] = '{0, 3, 1, 2, 1, 3, 0, 2};
        for (int p = 0; p < PHASES; p++) begin
            write_register(REG_FEATURE_COUNT, 3'(phase_fc[p]));
            write_register(REG_AMINO_FEATURE,
                           {1'($urandom), 2'(phase_af[p])});
            no_idle = (p == 2 || p == 5);
            send_random_items(220, (p == 0) ? 60 : 35);
            no_idle = 1'b0;
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        write_register(REG_FEATURE_COUNT, 3'd4);
        rsp_hold = HOLD_CYCLES;
        repeat (6) @(posedge i_clk);
        no_idle = 1'b1;
        send_random_items(40, 15);
        no_idle = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_NONE;
        req_bus.col_index     <= '0;
        req_bus.feature_index <= '0;
        req_bus.letter_index  <= '0;
        req_bus.score_value   <= '0;
        req_bus.feat_letter_0 <= '0;
        req_bus.feat_letter_1 <= '0;
        req_bus.feat_letter_2 <= '0;
        req_bus.feat_letter_3 <= '0;
        req_bus.amino_letter  <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_FEATURE_COUNT;
        cfg_bus.data          <= '0;
        // hot columns take most loads so queries find loaded entries
        hot_cols[0] = 0;
        hot_cols[1] = COLS - 1;
        for (int i = 2; i < 8; i++) hot_cols[i] = $urandom_range(1, COLS - 2);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_register_extremes();
        test_random_phases();
        test_backpressure();

        // drain: nothing owed, pipeline settled
        wait_drained();
        if (fail_count == 0 && pending_scores.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
